FILE: sv/job_deadline_sequencer_top_defines.svh
// Assertion macros used by the RTL of the job deadline sequencer.
`ifndef JOB_DEADLINE_SEQUENCER_TOP_DEFINES_SVH
`define JOB_DEADLINE_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every edge once reset has been released.
`define JDS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define JDS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JDS_ASSERT(label, prop, msg)
`define JDS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: sv/jds_pkg.sv
package jds_pkg;
	localparam int MAX_JOBS_DEF = 256;
	localparam int DL_W = 16;
	localparam int PR_W = 16;
	localparam int IN_TDATA_W = 32;
	localparam int CNT_OUT_W = 9;
	localparam int TOT_W = 24;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_SREQ,
		ST_SCHK,
		ST_FINISH
	} jds_state_t;
endpackage

FILE: sv/jds_ram.sv
module jds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/job_deadline_sequencer_top.sv
// Job deadline sequencer.
// Input stream: one transaction per job. tdata holds deadline [15:0] and
// profit [31:16]; tlast marks the final job of a set. Jobs load at one per
// cycle into a job memory; jobs beyond MAX_JOBS in one set are dropped, but
// their tlast still closes the set.
// After the final job the block stops taking input and schedules the set:
// a clearing pass over one slot per held job, then for each placed or
// skipped job one full scan of the job memory to select the next job in
// descending profit order, followed by a downward search of the slot
// memory, one slot probed at a time. A last scan that finds nothing ends
// the set. All of this runs through the single read port of each memory
// and one compare unit.
// Output stream: one transaction per set with job_count [8:0] and
// total_profit [32:9]. The result waits in an output register, and loading
// of the next set resumes at once even while the receiver stalls; a second
// result waits until the first has been taken.
// Reset empties the job store and drops any set in progress.
`include "job_deadline_sequencer_top_defines.svh"

module job_deadline_sequencer_top #(
	parameter int MAX_JOBS = jds_pkg::MAX_JOBS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// deadline [15:0], profit [31:16]
	input  logic [jds_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// job_count [8:0], total_profit [32:9], zero pad [39:33]
	output logic [jds_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import jds_pkg::*;

	localparam int AW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int KW = PR_W + AW;
	localparam int JW = CW + PR_W;
	localparam logic [CW-1:0] MAXC = CW'(MAX_JOBS);

	jds_state_t state_q, state_d;

	logic [CW-1:0]   cnt_q, n_q, idx_q, s_q, count_q, best_d_q;
	logic [TOT_W-1:0] total_q;
	logic [KW-1:0]   prev_key_q, best_key_q;
	logic            first_q, found_q;
	logic            valid_s1;
	logic [AW-1:0]   idx_s1;
	logic [AW-1:0]   idx_s1_q;
	logic            out_valid_q;
	logic [CNT_OUT_W-1:0] out_count_q;
	logic [TOT_W-1:0]     out_total_q;

	// Memory controls.
	logic            job_we;
	logic [AW-1:0]   job_raddr;
	logic [JW-1:0]   job_wdata, job_rdata;
	logic            slot_we, slot_wdata, slot_rdata;
	logic [AW-1:0]   slot_waddr, slot_raddr;

	logic [DL_W-1:0] in_dl;
	logic [PR_W-1:0] in_pr;
	logic [CW-1:0]   in_dl_clamped;
	logic            in_acc;
	logic            scan_start;
	logic [CW-1:0]   pick_s;
	logic [KW-1:0]   cand_key;
	logic            cand_ok;
	logic            out_free;

	assign in_dl = s_axis_tdata[DL_W-1:0];
	assign in_pr = s_axis_tdata[DL_W+PR_W-1:DL_W];
	// Deadlines past the capacity are clamped; that never changes the schedule.
	assign in_dl_clamped = (in_dl > DL_W'(MAX_JOBS)) ? MAXC : CW'(in_dl);
	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// Candidate for the next job in descending (profit, index) order.
	assign cand_key = {job_rdata[PR_W-1:0], idx_s1};
	assign cand_ok = (first_q || (cand_key < prev_key_q))
		&& (!found_q || (cand_key > best_key_q));

	// Within one set only the first n slots can ever be used.
	assign pick_s = (best_d_q > n_q) ? n_q : best_d_q;

	jds_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_job_ram (
		.clk   (clk),
		.we    (job_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (job_wdata),
		.raddr (job_raddr),
		.rdata (job_rdata)
	);

	jds_ram #(.WIDTH(1), .DEPTH(MAX_JOBS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job_we = 1'b0;
		job_wdata = {in_dl_clamped, in_pr};
		job_raddr = idx_q[AW-1:0];
		slot_we = 1'b0;
		slot_wdata = 1'b0;
		slot_waddr = idx_q[AW-1:0];
		slot_raddr = AW'(s_q - CW'(1));
		scan_start = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					job_we = (cnt_q < MAXC);
					if (s_axis_tlast) begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				slot_we = 1'b1;
				if (idx_q == n_q - CW'(1)) begin
					state_d = ST_SCAN;
					scan_start = 1'b1;
				end
			end
			ST_SCAN: begin
				if (idx_q == n_q - CW'(1)) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (!found_q) begin
					state_d = ST_FINISH;
				end else if (pick_s == '0) begin
					state_d = ST_SCAN;
					scan_start = 1'b1;
				end else begin
					state_d = ST_SREQ;
				end
			end
			ST_SREQ: begin
				state_d = ST_SCHK;
			end
			ST_SCHK: begin
				slot_waddr = AW'(s_q - CW'(1));
				if (!slot_rdata) begin
					slot_we = 1'b1;
					slot_wdata = 1'b1;
					state_d = ST_SCAN;
					scan_start = 1'b1;
				end else if (s_q == CW'(1)) begin
					state_d = ST_SCAN;
					scan_start = 1'b1;
				end else begin
					state_d = ST_SREQ;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			s_q <= '0;
			count_q <= '0;
			total_q <= '0;
			first_q <= 1'b1;
			found_q <= 1'b0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (s_axis_tlast) begin
							n_q <= (cnt_q < MAXC) ? cnt_q + CW'(1) : cnt_q;
							cnt_q <= '0;
							idx_q <= '0;
							count_q <= '0;
							total_q <= '0;
							first_q <= 1'b1;
						end else if (cnt_q < MAXC) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_CLEAR, ST_SCAN: begin
					idx_q <= idx_q + CW'(1);
				end
				ST_PICK: begin
					if (found_q) begin
						prev_key_q <= best_key_q;
						first_q <= 1'b0;
						s_q <= pick_s;
					end
				end
				ST_SCHK: begin
					if (!slot_rdata) begin
						count_q <= count_q + CW'(1);
						total_q <= total_q + TOT_W'(best_key_q[KW-1:AW]);
					end else begin
						s_q <= s_q - CW'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (scan_start) begin
				idx_q <= '0;
				found_q <= 1'b0;
			end else if (valid_s1 && cand_ok) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && cand_ok && !scan_start) begin
			best_key_q <= cand_key;
			best_d_q <= job_rdata[JW-1:PR_W];
		end
		if (state_q == ST_FINISH && out_free) begin
			out_count_q <= CNT_OUT_W'(count_q);
			out_total_q <= total_q;
		end
	end
	assign idx_s1 = idx_s1_q;
	always_ff @(posedge clk) begin
		idx_s1_q <= idx_q[AW-1:0];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {(OUT_TDATA_W-CNT_OUT_W-TOT_W)'(0), out_total_q, out_count_q};

	`JDS_ASSERT(a_cnt_cap, cnt_q <= MAXC, "load count beyond capacity")
	`JDS_ASSERT(a_count_le_n, (state_q != ST_LOAD) |-> (count_q <= n_q),
		"placed more jobs than loaded")
	`JDS_ASSERT(a_search_slot, (state_q == ST_SREQ) |-> (s_q != '0),
		"slot search below slot one")
	`JDS_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH),
		"result raised outside of finish")
endmodule
